// ----- design/heightmap_triangle_interpolator_assert.svh -----
// Assertion macros shared by the checker of the height interpolator.
// Depends on nothing; included by the checker file.
`ifndef HEIGHTMAP_TRIANGLE_INTERPOLATOR_ASSERT_SVH
`define HEIGHTMAP_TRIANGLE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/hti_pkg.sv -----
// Shared types and constants of the height interpolator.
// No dependencies; imported by every module of the block.
package hti_pkg;

	localparam int GRID_MAX_DEFAULT = 256;
	localparam int QUEUE_DEPTH      = 4;

	localparam logic [8:0]  GRID_SIZE_RESET    = 9'd256;
	localparam logic [15:0] HEIGHT_SCALE_RESET = 16'd256;

	// ceil(2^32 / 255): exact floor(m / 255) for any m below 2^24
	localparam logic [24:0] RECIP_255 = 25'd16843010;

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_QUERY = 1'b1
	} hti_func_t;

	typedef enum logic {
		REG_GRID_SIZE    = 1'b0,
		REG_HEIGHT_SCALE = 1'b1
	} hti_reg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} hti_qstat_t;

	// Width of one queued operation word for a given store address width.
	function automatic int hti_op_w(int aw);
		return 34 + 3 * aw;
	endfunction

endpackage

// ----- design/hti_front.sv -----
// Front end: takes input words, classifies writes and queries, checks range
// and forms row offsets. Depends on hti_pkg; feeds hti_queue.
module hti_front import hti_pkg::*; #(
	parameter int GRID_MAX = GRID_MAX_DEFAULT,
	parameter int AW       = $clog2(GRID_MAX * GRID_MAX),
	parameter int OP_W     = hti_op_w(AW)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	// sample_index[15:0], sample_value[23:16], pos_x[40:24], pos_z[57:41], zero pad
	input  logic [63:0]     s_tdata,
	// func[0]
	input  logic            s_tuser,
	input  logic [8:0]      grid_size,
	input  hti_qstat_t      qstat,
	output logic            push,
	output logic [OP_W-1:0] push_data
);

	localparam int DEPTH = GRID_MAX * GRID_MAX;
	localparam int SW    = $clog2(GRID_MAX + 1);
	localparam int EW    = (SW > 9) ? SW : 9;
	localparam int PW    = 9 + SW;

	typedef struct packed {
		logic          is_query;
		logic          in_range;
		logic [7:0]    u;
		logic [7:0]    v;
		logic [7:0]    ux;
		logic [AW-1:0] row0;
		logic [AW-1:0] row1;
		logic [AW-1:0] wr_addr;
		logic [7:0]    wr_data;
	} op_t;

	logic        v_s1;
	hti_func_t   func_s1;
	logic [15:0] idx_s1;
	logic [7:0]  val_s1;
	logic [16:0] px_s1;
	logic [16:0] pz_s1;

	logic [EW-1:0] size_e;
	logic [SW-1:0] size;
	logic [EW-1:0] xp1;
	logic [EW-1:0] zp1;
	logic [PW-1:0] prod0;
	logic [PW-1:0] prod1;
	logic          is_query;
	logic          in_range;
	logic          wr_ok;
	op_t           op;

	assign s_tready = !v_s1 || !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= hti_func_t'(s_tuser);
			idx_s1  <= s_tdata[15:0];
			val_s1  <= s_tdata[23:16];
			px_s1   <= s_tdata[40:24];
			pz_s1   <= s_tdata[57:41];
		end
	end

	always_comb begin
		// grid sizes above the store's edge act as the edge
		size_e = (EW'(grid_size) > EW'(GRID_MAX)) ? EW'(GRID_MAX) : EW'(grid_size);
		size   = SW'(size_e);
		xp1    = EW'(px_s1[15:8]) + EW'(1);
		zp1    = EW'(pz_s1[15:8]) + EW'(1);
		// floor of a negative position is a negative cell: outside
		in_range = !px_s1[16] && !pz_s1[16] && (xp1 < size_e) && (zp1 < size_e);
		prod0 = PW'(pz_s1[15:8]) * PW'(size);
		prod1 = PW'(zp1[8:0]) * PW'(size);
		is_query = (func_s1 == FUNC_QUERY);
		wr_ok    = 32'(idx_s1) < 32'(DEPTH);

		op.is_query = is_query;
		op.in_range = in_range;
		op.u        = px_s1[7:0];
		op.v        = pz_s1[7:0];
		op.ux       = px_s1[15:8];
		op.row0     = AW'(prod0);
		op.row1     = AW'(prod1);
		op.wr_addr  = AW'(idx_s1);
		op.wr_data  = val_s1;
	end

	// writes beyond the store are dropped here
	assign push      = v_s1 && !qstat.full && (is_query || wr_ok);
	assign push_data = op;

endmodule

// ----- design/hti_queue.sv -----
// Short FIFO of classified operation words between front and back.
// Depends on hti_pkg.
module hti_queue import hti_pkg::*; #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output hti_qstat_t   stat
);

	localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]    slot_q [QUEUE_DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CNTW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTRW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNTW'(1);
				2'b01:   count_q <= count_q - CNTW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data   = slot_q[rd_ptr_q];
	assign stat.full  = (count_q == CNTW'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

// ----- design/hti_back.sv -----
// Back end: height store (two copies for three reads), corner weighting,
// scaling and divide by 255*256, output register. Depends on hti_pkg.
module hti_back import hti_pkg::*; #(
	parameter int GRID_MAX = GRID_MAX_DEFAULT,
	parameter int AW       = $clog2(GRID_MAX * GRID_MAX),
	parameter int OP_W     = hti_op_w(AW)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  hti_qstat_t      qstat,
	output logic            pop,
	input  logic [OP_W-1:0] pop_data,
	input  logic [15:0]     height_scale,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [23:0]     out_height,
	output logic            out_in_range
);

	localparam int DEPTH = GRID_MAX * GRID_MAX;

	typedef struct packed {
		logic          is_query;
		logic          in_range;
		logic [7:0]    u;
		logic [7:0]    v;
		logic [7:0]    ux;
		logic [AW-1:0] row0;
		logic [AW-1:0] row1;
		logic [AW-1:0] wr_addr;
		logic [7:0]    wr_data;
	} op_t;

	logic [7:0] mem_a_q [DEPTH];
	logic [7:0] mem_b_q [DEPTH];

	op_t           op;
	logic          adv;
	logic          do_write;
	logic [AW-1:0] addr_bl;
	logic [AW-1:0] addr_br;
	logic [AW-1:0] addr_tl;
	logic [AW-1:0] addr_tr;
	logic [AW-1:0] addr_b;
	logic          gt;
	logic [7:0]    diff;
	logic [8:0]    w_bl;
	logic [8:0]    w_b;
	logic [8:0]    w_tr;
	logic [17:0]   sum_w;
	logic [48:0]   recip;

	logic        v_s1, q_s1, ir_s1;
	logic [8:0]  w_bl_s1, w_b_s1, w_tr_s1;
	logic [7:0]  rd_bl_s1, rd_b_s1, rd_tr_s1;
	logic        v_s2, ir_s2;
	logic [16:0] p_bl_s2, p_b_s2, p_tr_s2;
	logic        v_s3, ir_s3;
	logic [15:0] sum_s3;
	logic        v_s4, ir_s4;
	logic [31:0] prod_s4;
	logic        v_s5, ir_s5;
	logic [15:0] height_s5;

	// whole back pipeline moves unless a finished word is held at the output
	assign adv      = !v_s5 || out_ready;
	assign pop      = adv && !qstat.empty;
	assign op       = pop_data;
	assign do_write = pop && !op.is_query;

	always_comb begin
		addr_bl = op.row0 + AW'(op.ux);
		addr_br = addr_bl + AW'(1);
		addr_tl = op.row1 + AW'(op.ux);
		addr_tr = addr_tl + AW'(1);
		// lower-right triangle when u > v, else upper-left
		gt     = op.u > op.v;
		addr_b = gt ? addr_br : addr_tl;
		diff   = gt ? (op.u - op.v) : (op.v - op.u);
		w_b    = {1'b0, diff};
		w_tr   = {1'b0, gt ? op.v : op.u};
		w_bl   = 9'd256 - {1'b0, gt ? op.u : op.v};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (do_write) begin
				mem_a_q[op.wr_addr] <= op.wr_data;
			end
			rd_bl_s1 <= mem_a_q[addr_bl];
			rd_tr_s1 <= mem_a_q[addr_tr];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (do_write) begin
				mem_b_q[op.wr_addr] <= op.wr_data;
			end
			rd_b_s1 <= mem_b_q[addr_b];
		end
	end

	always_comb begin
		sum_w = 18'(p_bl_s2) + 18'(p_b_s2) + 18'(p_tr_s2);
		recip = 49'(prod_s4[31:8]) * 49'(RECIP_255);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1 && q_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s1    <= op.is_query;
			ir_s1   <= op.in_range;
			w_bl_s1 <= w_bl;
			w_b_s1  <= w_b;
			w_tr_s1 <= w_tr;

			ir_s2   <= ir_s1;
			p_bl_s2 <= 17'(rd_bl_s1) * 17'(w_bl_s1);
			p_b_s2  <= 17'(rd_b_s1) * 17'(w_b_s1);
			p_tr_s2 <= 17'(rd_tr_s1) * 17'(w_tr_s1);

			// weights sum to 256, so the total stays within 16 bits
			ir_s3  <= ir_s2;
			sum_s3 <= sum_w[15:0];

			ir_s4   <= ir_s3;
			prod_s4 <= 32'(sum_s3) * 32'(height_scale);

			// divide by 256 with the shift, by 255 with the reciprocal
			ir_s5     <= ir_s4;
			height_s5 <= ir_s4 ? recip[47:32] : '0;
		end
	end

	assign out_valid    = v_s5;
	assign out_height   = {8'b0, height_s5};
	assign out_in_range = ir_s5;

endmodule

// ----- design/heightmap_triangle_interpolator.sv -----
// Top level of the height interpolator: configuration registers, front end,
// operation queue and back end. Depends on hti_pkg, hti_front, hti_queue, hti_back.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid / s_tready  tdata: index, value, pos_x, pos_z; tuser: func
//   m_*      out  m_tvalid / m_tready  tdata: height; tuser: in_range
//   cfg_*    in   cfg_we               cfg_addr selects register, cfg_wdata value
//
// One word per cycle on both streams while nothing stalls; the edge that takes a
// query word loads the front register, then its result passes a queue slot and
// five back stages. The store is two copies of the sample memory, so the three
// corner reads of a query happen in the same cycle. Samples hold no defined value
// after reset until written; there is no clearing pass. A stalled output holds the
// back pipeline while the 4-word queue keeps the input side taking words until
// it fills.
module heightmap_triangle_interpolator import hti_pkg::*; #(
	parameter int GRID_MAX = GRID_MAX_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// sample_index[15:0], sample_value[23:16], pos_x[40:24], pos_z[57:41], zero pad
	input  logic [63:0] s_tdata,
	// func[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// height[23:0]
	output logic [23:0] m_tdata,
	// in_range[0]
	output logic        m_tuser,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	localparam int AW   = $clog2(GRID_MAX * GRID_MAX);
	localparam int OP_W = hti_op_w(AW);

	logic [8:0]      grid_size_q;
	logic [15:0]     height_scale_q;
	hti_qstat_t      qstat;
	logic            push;
	logic [OP_W-1:0] push_data;
	logic            pop;
	logic [OP_W-1:0] pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q    <= GRID_SIZE_RESET;
			height_scale_q <= HEIGHT_SCALE_RESET;
		end else if (cfg_we) begin
			case (hti_reg_t'(cfg_addr))
				REG_GRID_SIZE:    grid_size_q    <= cfg_wdata[8:0];
				REG_HEIGHT_SCALE: height_scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	hti_front #(
		.GRID_MAX (GRID_MAX),
		.AW       (AW),
		.OP_W     (OP_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.grid_size (grid_size_q),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	hti_queue #(
		.W (OP_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (qstat)
	);

	hti_back #(
		.GRID_MAX (GRID_MAX),
		.AW       (AW),
		.OP_W     (OP_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.pop          (pop),
		.pop_data     (pop_data),
		.height_scale (height_scale_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_height   (m_tdata),
		.out_in_range (m_tuser)
	);

endmodule

// ----- design/hti_checker.sv -----
// Port-level checks on the result stream of the height interpolator, bound to
// the top level. Depends on heightmap_triangle_interpolator_assert.svh.
`include "heightmap_triangle_interpolator_assert.svh"

module hti_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);

	// a held result keeps its word
	`HTI_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

	// outside the grid the height is zero
	`HTI_ASSERT_NOW(a_outside_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == 24'd0, "nonzero height outside grid")

	// the scaled height never exceeds 65535
	`HTI_ASSERT_NOW(a_height_bound, clk, arst_n, m_tvalid, m_tdata[23:16] == 8'd0, "height above full scale")

endmodule

bind heightmap_triangle_interpolator hti_checker u_hti_checker (.*);

// ----- test/hti_result_checker.sv -----
`timescale 1ns / 100ps
// Checker of the height interpolator: keeps its own copy of the sample store and
// registers, works out each query answer and compares it with the output stream.
// Depends on hti_pkg; instantiated beside the block by the testbench top.
module hti_result_checker import hti_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        m_tuser,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	output int          mismatch_count,
	output int          answers_due
);

	localparam int         STORE_DEPTH    = 65536;
	localparam int         CELL_LIMIT     = 256;
	localparam int         FULL_SCALE_DIV = 255 * 256;
	localparam int         MAX_PRINTS     = 40;
	localparam logic [8:0]  GRID_AT_RESET  = 9'd256;
	localparam logic [15:0] SCALE_AT_RESET = 16'd256;

	typedef struct packed {
		logic [23:0] height;
		logic        in_range;
	} answer_t;

	logic [7:0]  samples [STORE_DEPTH];
	logic [8:0]  grid_size;
	logic [15:0] height_scale;
	answer_t     answer_q [$];
	int          errors = 0;

	assign mismatch_count = errors;

	function automatic answer_t height_at(logic [16:0] px, logic [16:0] pz);
		int      esz, cx, cz, u, v, base, bl, br, tl, tr, s;
		longint  scaled;
		answer_t a;
		a = '0;
		esz = (grid_size > CELL_LIMIT) ? CELL_LIMIT : int'(grid_size);
		// cell is the floor of the position, fraction is the low byte
		cx = $signed(px[16:8]);
		cz = $signed(pz[16:8]);
		u = px[7:0];
		v = pz[7:0];
		if (cx < 0 || cz < 0 || cx + 1 >= esz || cz + 1 >= esz)
			return a;
		base = cx + cz * esz;
		bl = samples[16'(base)];
		br = samples[16'(base + 1)];
		tl = samples[16'(base + esz)];
		tr = samples[16'(base + esz + 1)];
		if (u > v)
			s = br * (u - v) + tr * v + bl * (256 - u);
		else
			s = tl * (v - u) + tr * u + bl * (256 - v);
		scaled = longint'(s) * longint'(height_scale) / FULL_SCALE_DIV;
		a.height = scaled[23:0];
		a.in_range = 1'b1;
		return a;
	endfunction

	task automatic flag_mismatch(string field, longint want, longint got);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			grid_size = GRID_AT_RESET;
			height_scale = SCALE_AT_RESET;
			answer_q.delete();
			answers_due = 0;
		end else begin
			// output side first, so a word taken this edge is never matched at once
			if (m_tvalid && m_tready) begin
				if (answer_q.size() == 0) begin
					flag_mismatch("unexpected answer, height", -1, m_tdata);
				end else begin
					want = answer_q.pop_front();
					if (m_tdata !== want.height)
						flag_mismatch("height", want.height, m_tdata);
					if (m_tuser !== want.in_range)
						flag_mismatch("in_range", want.in_range, m_tuser);
				end
			end
			if (s_tvalid && s_tready) begin
				if (hti_func_t'(s_tuser) == FUNC_QUERY)
					answer_q = {answer_q, height_at(s_tdata[40:24], s_tdata[57:41])};
				else
					samples[s_tdata[15:0]] = s_tdata[23:16];
			end
			if (cfg_we) begin
				case (hti_reg_t'(cfg_addr))
					REG_GRID_SIZE:    grid_size = cfg_wdata[8:0];
					REG_HEIGHT_SCALE: height_scale = cfg_wdata;
					default: ;
				endcase
			end
			answers_due = answer_q.size();
		end
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Top of the height interpolator test: clock, reset, sample writes, queries and
// register phases. Depends on hti_pkg, the block and hti_result_checker.
module testbench import hti_pkg::*; ();

	localparam int CELL_LIMIT     = 256;
	localparam int SETTLE_CYCLES  = 16;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int NUM_PHASES     = 12;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we;
	logic [0:0]  cfg_addr;
	logic [15:0] cfg_wdata;
	int          mismatch_count;
	int          answers_due;

	int tx_idle_pct;
	int rx_stall_pct;
	int rx_hold_requests;
	int words_sent;
	int grid_now;
	bit written [65536];

	heightmap_triangle_interpolator u_top (.*);
	hti_result_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// output side: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int hold_seen, hold_left;
		hold_seen = 0;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_requests != hold_seen) begin
				hold_seen = rx_hold_requests;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	task automatic put_word(hti_func_t f, logic [15:0] idx, logic [7:0] val,
			logic [16:0] px, logic [16:0] pz);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= {6'b0, pz, px, val, idx};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_write(logic [15:0] idx, logic [7:0] val);
		written[idx] = 1'b1;
		put_word(FUNC_WRITE, idx, val, 17'($urandom), 17'($urandom));
	endtask

	// corners of an in-grid cell get written first, so no unwritten sample is read
	task automatic send_query(int x, int z);
		logic [16:0] px, pz;
		int esz, cx, cz, idx;
		px = x[16:0];
		pz = z[16:0];
		cx = $signed(px[16:8]);
		cz = $signed(pz[16:8]);
		esz = (grid_now > CELL_LIMIT) ? CELL_LIMIT : grid_now;
		if (cx >= 0 && cz >= 0 && cx + 1 < esz && cz + 1 < esz) begin
			for (int dz = 0; dz < 2; dz++) begin
				for (int dx = 0; dx < 2; dx++) begin
					idx = (cx + dx) + (cz + dz) * esz;
					if (!written[16'(idx)])
						send_write(16'(idx), 8'($urandom));
				end
			end
		end
		put_word(FUNC_QUERY, 16'($urandom), 8'($urandom), px, pz);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (answers_due != 0)
			@(negedge clk);
	endtask

	task automatic set_register(hti_reg_t r, int val);
		drain();
		// writes give no answer and may still be in flight
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= r;
		cfg_wdata <= val[15:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (r == REG_GRID_SIZE)
			grid_now = val & 'h1FF;
	endtask

	task automatic run_phase(int n_words, int tx_pct, int rx_pct, bit long_hold, bit mid_pause);
		int esz, first, roll, cx, cz, u, v, tmp;
		bit paused;
		esz = (grid_now > CELL_LIMIT) ? CELL_LIMIT : grid_now;
		first = words_sent;
		paused = 1'b0;
		if (long_hold)
			rx_hold_requests++;
		while (words_sent - first < n_words) begin
			if (((words_sent - first) / 50) % 3 == 2) begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end else begin
				tx_idle_pct = tx_pct;
				rx_stall_pct = rx_pct;
			end
			if (mid_pause && !paused && words_sent - first >= n_words / 2) begin
				drain();
				paused = 1'b1;
			end
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				send_write(16'($urandom), 8'($urandom));
			end else if (roll < 25) begin
				send_query($urandom, $urandom);
			end else if (roll < 35 || esz < 2) begin
				// just outside an edge of the grid, or far out
				case ($urandom_range(0, 3))
					0:       cx = -1;
					1:       cx = esz - 1;
					2:       cx = -256;
					default: cx = 255;
				endcase
				cz = ($urandom_range(0, 1) || esz < 2) ? cx : $urandom_range(0, esz - 2);
				if ($urandom_range(0, 1)) begin
					tmp = cx;
					cx = cz;
					cz = tmp;
				end
				send_query(cx * 256 + $urandom_range(0, 255), cz * 256 + $urandom_range(0, 255));
			end else begin
				if ($urandom_range(0, 3) == 0)
					cx = $urandom_range(0, 1) ? 0 : esz - 2;
				else
					cx = $urandom_range(0, esz - 2);
				if ($urandom_range(0, 3) == 0)
					cz = $urandom_range(0, 1) ? 0 : esz - 2;
				else
					cz = $urandom_range(0, esz - 2);
				u = $urandom_range(0, 255);
				case ($urandom_range(0, 9))
					0, 1:    v = u;
					2: begin
						u = 0;
						v = 255;
					end
					3: begin
						u = 255;
						v = 0;
					end
					4:       v = (u == 255) ? 254 : u + 1;
					default: v = $urandom_range(0, 255);
				endcase
				send_query(cx * 256 + u, cz * 256 + v);
			end
		end
	endtask

	initial begin
		int g, sc, n;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_requests = 0;
		words_sent = 0;
		grid_now = 256;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners of the first and the last cell at the reset grid size
		send_write(0, 255);
		send_write(1, 0);
		send_write(256, 128);
		send_write(257, 255);
		send_write(65278, 200);
		send_write(65279, 1);
		send_write(65534, 0);
		send_write(65535, 255);
		send_query(0, 0);
		send_query(200, 10);
		send_query(3, 250);
		send_query(128, 128);
		send_query(65279, 65279);
		send_query(-1, 0);
		send_query(-65536, 65535);
		send_query(65280, 0);
		send_query(0, -256);

		for (int p = 0; p < NUM_PHASES; p++) begin
			n = 170;
			case (p)
				0: begin g = 256; sc = 65535; end
				1: begin g = 2; sc = 0; n = 100; end
				2: begin g = 0; sc = 256; n = 50; end
				3: begin g = 1; sc = 1; n = 50; end
				4: begin g = 511; sc = 255; end
				5: begin g = 3; sc = 65535; n = 150; end
				6: begin g = $urandom_range(4, 255); sc = $urandom_range(0, 65535); end
				7: begin g = 257; sc = 256; n = 150; end
				8: begin g = 16; sc = $urandom_range(0, 65535); end
				9: begin g = 255; sc = 65535; end
				10: begin g = $urandom_range(2, 64); sc = $urandom_range(0, 65535); end
				default: begin g = 256; sc = 256; n = 150; end
			endcase
			set_register(REG_GRID_SIZE, g);
			set_register(REG_HEIGHT_SCALE, sc);
			case (p % 4)
				0:       run_phase(n, 0, 0, p == 0, p == 4);
				1:       run_phase(n, 63, 0, 1'b0, 1'b0);
				2:       run_phase(n, 0, 63, 1'b0, 1'b0);
				default: run_phase(n, 31, 31, 1'b0, 1'b0);
			endcase
		end

		tx_idle_pct = 0;
		rx_stall_pct = 0;
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
